### hdl/fsl_pkg.sv
`timescale 1ns / 1ps
package fsl_pkg;

   // Queue between the framing front and the result back
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes
   localparam logic [2:0] CSR_LINK_ENABLE = 3'd0;
   localparam logic [2:0] CSR_START_BYTE  = 3'd1;
   localparam logic [2:0] CSR_END_BYTE    = 3'd2;
   localparam logic [2:0] CSR_HELLO_FRAME = 3'd3;
   localparam logic [2:0] CSR_ACK_FRAME   = 3'd4;
   localparam logic [2:0] CSR_READY_FRAME = 3'd5;
   localparam logic [2:0] CSR_SENSOR_ID   = 3'd6;

   // Register reset values
   localparam logic        RST_LINK_ENABLE = 1'b1;
   localparam logic [7:0]  RST_START_BYTE  = 8'd60;
   localparam logic [7:0]  RST_END_BYTE    = 8'd62;
   localparam logic [39:0] RST_FRAME       = 40'd0;
   localparam logic [4:0]  RST_SENSOR_ID   = 5'd0;

   // Result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_READING = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_BAD_START  = 3'd0;
   localparam logic [2:0] ERR_BAD_END    = 3'd1;
   localparam logic [2:0] ERR_HELLO      = 3'd2;
   localparam logic [2:0] ERR_ID_TAG     = 3'd3;
   localparam logic [2:0] ERR_ID_MISMATCH = 3'd4;

   // Id frame tag characters
   localparam logic [7:0] CHAR_I = 8'h69;
   localparam logic [7:0] CHAR_D = 8'h64;

   // Frame layout: position of the end marker, index of the last sent byte
   localparam logic [2:0] POS_START = 3'd0;
   localparam logic [2:0] POS_END   = 3'd4;
   localparam logic [2:0] LAST_BYTE_IDX = 3'd4;

   typedef enum logic [3:0] {
      PH_HELLO = 4'b0001,
      PH_ID    = 4'b0010,
      PH_DATA  = 4'b0100,
      PH_HALT  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic        link_enable;
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [39:0] hello_frame;
      logic [39:0] ack_frame;
      logic [39:0] ready_frame;
      logic [4:0]  sensor_id;
   } cfg_type;

   // One queued command: either a single result or a whole frame to send
   typedef struct packed {
      logic        is_frame;
      logic [1:0]  kind;
      logic [2:0]  err_code;
      logic [15:0] reading;
      logic [39:0] frame;
   } cmd_type;

   typedef struct packed {
      logic halted;
      logic accepted;
   } front_status_type;

   function automatic cmd_type make_error(input logic [2:0] code);
      cmd_type c;
      c          = '0;
      c.kind     = KIND_ERROR;
      c.err_code = code;
      return c;
   endfunction

endpackage

### hdl/fsl_req_if.sv
`timescale 1ns / 1ps
interface fsl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/fsl_rsp_if.sv
`timescale 1ns / 1ps
interface fsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  tx_byte;
   logic [15:0] reading;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, output result_kind, output tx_byte, output reading,
                   output error_code, output last, input ready);
   modport sink (input valid, input result_kind, input tx_byte, input reading,
                 input error_code, input last, output ready);
endinterface

### hdl/framed_sensor_link_handshake.sv
// A byte's command is registered in the command queue, then its first result in the output stage.
// Throughput: one byte per cycle while the command queue has room; the back end
// emits one result per cycle while the receiver is ready, so a frame reply is five results.
// Up to QueueDepth commands buffer between framing and result output.
// Reset (synchronous, active high): registers take their defaults, framing waits
// for a start marker, the handshake waits for hello, the queue and output empty.
`timescale 1ns / 1ps
module framed_sensor_link_handshake #(
   parameter int QueueDepth = fsl_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   fsl_req_if.sink     req_bus,
   fsl_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [39:0] csr_wdata
);

   fsl_pkg::cfg_type          cfg_ff, cfg_in;
   fsl_pkg::cmd_type          push_cmd;
   fsl_pkg::cmd_type          head_cmd;
   fsl_pkg::front_status_type front_status;
   logic                      push_valid;
   logic                      queue_full;
   logic                      head_valid;
   logic                      pop;

   // Configuration register file: take a write on any cycle with the enable
   // high, mask data to the register width, drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fsl_pkg::CSR_LINK_ENABLE: cfg_in.link_enable = csr_wdata[0];
            fsl_pkg::CSR_START_BYTE:  cfg_in.start_byte  = csr_wdata[7:0];
            fsl_pkg::CSR_END_BYTE:    cfg_in.end_byte    = csr_wdata[7:0];
            fsl_pkg::CSR_HELLO_FRAME: cfg_in.hello_frame = csr_wdata;
            fsl_pkg::CSR_ACK_FRAME:   cfg_in.ack_frame   = csr_wdata;
            fsl_pkg::CSR_READY_FRAME: cfg_in.ready_frame = csr_wdata;
            fsl_pkg::CSR_SENSOR_ID:   cfg_in.sensor_id   = csr_wdata[4:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_enable <= fsl_pkg::RST_LINK_ENABLE;
         cfg_ff.start_byte  <= fsl_pkg::RST_START_BYTE;
         cfg_ff.end_byte    <= fsl_pkg::RST_END_BYTE;
         cfg_ff.hello_frame <= fsl_pkg::RST_FRAME;
         cfg_ff.ack_frame   <= fsl_pkg::RST_FRAME;
         cfg_ff.ready_frame <= fsl_pkg::RST_FRAME;
         cfg_ff.sensor_id   <= fsl_pkg::RST_SENSOR_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: assemble frames, advance the handshake phase, and turn each
   // byte into at most one command for the back end.
   fsl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .status     (front_status)
   );

   // Queue: decouple framing from result delivery so a five-byte reply
   // does not stall the incoming byte stream.
   fsl_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   // Back: expand each command into its result transactions, one per cycle while
   // the receiver is ready, through a registered output stage.
   fsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTH
   // Never push a command into a full queue.
   assert property (@(posedge clock) disable iff (reset) push_valid |-> !queue_full)
      else $error("command pushed into full queue");

   // Once halted, the link stays halted until reset.
   assert property (@(posedge clock) disable iff (reset)
      front_status.halted |=> front_status.halted)
      else $error("link left halted phase");

   // A halted link produces no commands for accepted bytes.
   assert property (@(posedge clock) disable iff (reset)
      (front_status.halted && front_status.accepted) |-> !push_valid)
      else $error("halted link produced a command");

   // Readings and errors are single results and always close their byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.result_kind != fsl_pkg::KIND_TX)) |-> rsp_bus.last)
      else $error("single result without last flag");
`endif

endmodule

### hdl/fsl_front.sv
`timescale 1ns / 1ps
module fsl_front (
   input  logic                       clock,
   input  logic                       reset,
   fsl_req_if.sink                    req_bus,
   input  fsl_pkg::cfg_type           cfg,
   input  logic                       queue_full,
   output logic                       push_valid,
   output fsl_pkg::cmd_type           push_cmd,
   output fsl_pkg::front_status_type  status
);

   fsl_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         data_ff [3];
   logic               accept;
   logic               active;
   logic [39:0]        whole;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign active        = cfg.link_enable && (phase_ff != fsl_pkg::PH_HALT);
   assign whole         = {cfg.start_byte, data_ff[0], data_ff[1], data_ff[2], cfg.end_byte};

   assign status.halted   = (phase_ff == fsl_pkg::PH_HALT);
   assign status.accepted = accept;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      push_valid = 1'b0;
      push_cmd   = '0;
      if (accept && active) begin
         case (pos_ff) inside
            fsl_pkg::POS_START: begin
               if (req_bus.rx_byte == cfg.start_byte) begin
                  pos_in = 3'd1;
               end else begin
                  push_valid = 1'b1;
                  push_cmd   = fsl_pkg::make_error(fsl_pkg::ERR_BAD_START);
               end
            end
            3'd1, 3'd2, 3'd3: begin
               pos_in = pos_ff + 3'd1;
            end
            fsl_pkg::POS_END: begin
               pos_in     = fsl_pkg::POS_START;
               push_valid = 1'b1;
               if (req_bus.rx_byte != cfg.end_byte) begin
                  push_cmd = fsl_pkg::make_error(fsl_pkg::ERR_BAD_END);
               end else begin
                  unique case (phase_ff)
                     fsl_pkg::PH_HELLO: begin
                        if (whole == cfg.hello_frame) begin
                           push_cmd.is_frame = 1'b1;
                           push_cmd.kind     = fsl_pkg::KIND_TX;
                           push_cmd.frame    = cfg.ack_frame;
                           phase_in          = fsl_pkg::PH_ID;
                        end else begin
                           push_cmd = fsl_pkg::make_error(fsl_pkg::ERR_HELLO);
                        end
                     end
                     fsl_pkg::PH_ID: begin
                        if (data_ff[1] == fsl_pkg::CHAR_I && data_ff[2] == fsl_pkg::CHAR_D) begin
                           if (data_ff[0] == {3'b000, cfg.sensor_id}) begin
                              push_cmd.is_frame = 1'b1;
                              push_cmd.kind     = fsl_pkg::KIND_TX;
                              push_cmd.frame    = cfg.ready_frame;
                              phase_in          = fsl_pkg::PH_DATA;
                           end else begin
                              push_cmd = fsl_pkg::make_error(fsl_pkg::ERR_ID_MISMATCH);
                              phase_in = fsl_pkg::PH_HALT;
                           end
                        end else begin
                           push_cmd = fsl_pkg::make_error(fsl_pkg::ERR_ID_TAG);
                        end
                     end
                     fsl_pkg::PH_DATA: begin
                        push_cmd.kind    = fsl_pkg::KIND_READING;
                        push_cmd.reading = {data_ff[1], data_ff[2]};
                     end
                     default: begin
                        push_valid = 1'b0;
                     end
                  endcase
               end
            end
            default: begin
               pos_in = fsl_pkg::POS_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fsl_pkg::PH_HELLO;
         pos_ff   <= fsl_pkg::POS_START;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // capture data bytes one to three at their fixed frame positions
   always_ff @(posedge clock) begin
      if (accept && active) begin
         if (pos_ff == 3'd1) data_ff[0] <= req_bus.rx_byte;
         if (pos_ff == 3'd2) data_ff[1] <= req_bus.rx_byte;
         if (pos_ff == 3'd3) data_ff[2] <= req_bus.rx_byte;
      end
   end

endmodule

### hdl/fsl_queue.sv
`timescale 1ns / 1ps
module fsl_queue #(
   parameter int Depth = fsl_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  fsl_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             head_valid,
   output fsl_pkg::cmd_type head_cmd,
   input  logic             pop
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   fsl_pkg::cmd_type  entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CountW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/fsl_back.sv
`timescale 1ns / 1ps
module fsl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  fsl_pkg::cmd_type head_cmd,
   output logic             pop,
   fsl_rsp_if.source        rsp_bus
);

   logic        rsp_valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic [15:0] reading_ff, reading_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;
   logic [2:0]  idx_ff, idx_in;
   logic        load;
   logic [7:0]  frame_byte;

   assign load = head_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      case (idx_ff)
         3'd0:    frame_byte = head_cmd.frame[39:32];
         3'd1:    frame_byte = head_cmd.frame[31:24];
         3'd2:    frame_byte = head_cmd.frame[23:16];
         3'd3:    frame_byte = head_cmd.frame[15:8];
         default: frame_byte = head_cmd.frame[7:0];
      endcase
   end

   always_comb begin
      idx_in     = idx_ff;
      pop        = 1'b0;
      kind_in    = head_cmd.kind;
      tx_in      = 8'd0;
      reading_in = head_cmd.reading;
      err_in     = head_cmd.err_code;
      last_in    = 1'b1;
      if (head_cmd.is_frame) begin
         tx_in      = frame_byte;
         reading_in = 16'd0;
         err_in     = 3'd0;
         last_in    = (idx_ff == fsl_pkg::LAST_BYTE_IDX);
      end
      if (load) begin
         pop    = last_in;
         idx_in = last_in ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         tx_ff      <= tx_in;
         reading_ff <= reading_in;
         err_ff     <= err_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_kind = kind_ff;
   assign rsp_bus.tx_byte     = tx_ff;
   assign rsp_bus.reading     = reading_ff;
   assign rsp_bus.error_code  = err_ff;
   assign rsp_bus.last        = last_ff;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   // Run limit and the quiet time allowed after the last expected result
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int SETTLE_CYCLES = 10;

   // Index past the register file: a write there must change nothing
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  tx_byte;
      logic [15:0] reading;
      logic [2:0]  error_code;
      logic        last;
   } link_result_type;

   // Tracks the link as the block should see it and holds the results still owed.
   class link_scoreboard;
      fsl_pkg::cfg_type   cfg;
      fsl_pkg::phase_type phase;
      logic [2:0]         frame_pos;
      logic [7:0]         frame_bytes [3];
      link_result_type    expected_results [$];
      int                 failures;

      function new();
         cfg.link_enable = fsl_pkg::RST_LINK_ENABLE;
         cfg.start_byte  = fsl_pkg::RST_START_BYTE;
         cfg.end_byte    = fsl_pkg::RST_END_BYTE;
         cfg.hello_frame = fsl_pkg::RST_FRAME;
         cfg.ack_frame   = fsl_pkg::RST_FRAME;
         cfg.ready_frame = fsl_pkg::RST_FRAME;
         cfg.sensor_id   = fsl_pkg::RST_SENSOR_ID;
         phase           = fsl_pkg::PH_HELLO;
         frame_pos       = fsl_pkg::POS_START;
         failures        = 0;
         foreach (frame_bytes[k]) frame_bytes[k] = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [39:0] value);
         case (idx)
            fsl_pkg::CSR_LINK_ENABLE: cfg.link_enable = value[0];
            fsl_pkg::CSR_START_BYTE:  cfg.start_byte  = value[7:0];
            fsl_pkg::CSR_END_BYTE:    cfg.end_byte    = value[7:0];
            fsl_pkg::CSR_HELLO_FRAME: cfg.hello_frame = value;
            fsl_pkg::CSR_ACK_FRAME:   cfg.ack_frame   = value;
            fsl_pkg::CSR_READY_FRAME: cfg.ready_frame = value;
            fsl_pkg::CSR_SENSOR_ID:   cfg.sensor_id   = value[4:0];
            default: ;
         endcase
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] tx, logic [15:0] value,
                                logic [2:0] code, logic is_last);
         expected_results.push_back({kind, tx, value, code, is_last});
      endfunction

      function void push_frame(logic [39:0] frame);
         for (int k = 0; k < 5; k++)
            push_result(fsl_pkg::KIND_TX, 8'(frame >> (8 * (4 - k))), '0, '0, k == 4);
      endfunction

      function logic [39:0] whole_frame();
         return {cfg.start_byte, frame_bytes[0], frame_bytes[1], frame_bytes[2],
                 cfg.end_byte};
      endfunction

      // True when this byte would close a frame that advances the handshake
      function bit moves_phase(logic [7:0] b);
         if (!cfg.link_enable || phase == fsl_pkg::PH_HALT) return 1'b0;
         if (frame_pos != fsl_pkg::POS_END || b != cfg.end_byte) return 1'b0;
         if (phase == fsl_pkg::PH_HELLO) return whole_frame() == cfg.hello_frame;
         if (phase == fsl_pkg::PH_ID)
            return frame_bytes[1] == fsl_pkg::CHAR_I && frame_bytes[2] == fsl_pkg::CHAR_D;
         return 1'b0;
      endfunction

      function void note_byte(logic [7:0] b);
         if (!cfg.link_enable || phase == fsl_pkg::PH_HALT) return;
         if (frame_pos == fsl_pkg::POS_START) begin
            if (b == cfg.start_byte) frame_pos = 3'd1;
            else push_result(fsl_pkg::KIND_ERROR, '0, '0, fsl_pkg::ERR_BAD_START, 1'b1);
         end else if (frame_pos != fsl_pkg::POS_END) begin
            frame_bytes[2'(frame_pos - 3'd1)] = b;
            frame_pos = frame_pos + 3'd1;
         end else begin
            frame_pos = fsl_pkg::POS_START;
            if (b != cfg.end_byte) begin
               push_result(fsl_pkg::KIND_ERROR, '0, '0, fsl_pkg::ERR_BAD_END, 1'b1);
            end else if (phase == fsl_pkg::PH_HELLO) begin
               if (whole_frame() == cfg.hello_frame) begin
                  push_frame(cfg.ack_frame);
                  phase = fsl_pkg::PH_ID;
               end else begin
                  push_result(fsl_pkg::KIND_ERROR, '0, '0, fsl_pkg::ERR_HELLO, 1'b1);
               end
            end else if (phase == fsl_pkg::PH_ID) begin
               if (frame_bytes[1] != fsl_pkg::CHAR_I || frame_bytes[2] != fsl_pkg::CHAR_D) begin
                  push_result(fsl_pkg::KIND_ERROR, '0, '0, fsl_pkg::ERR_ID_TAG, 1'b1);
               end else if (frame_bytes[0] == {3'b000, cfg.sensor_id}) begin
                  push_frame(cfg.ready_frame);
                  phase = fsl_pkg::PH_DATA;
               end else begin
                  push_result(fsl_pkg::KIND_ERROR, '0, '0, fsl_pkg::ERR_ID_MISMATCH, 1'b1);
                  phase = fsl_pkg::PH_HALT;
               end
            end else begin
               push_result(fsl_pkg::KIND_READING, '0, {frame_bytes[1], frame_bytes[2]},
                           '0, 1'b1);
            end
         end
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(link_result_type got);
         link_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d tx 0x%0h reading 0x%0h code %0d",
                   got.result_kind, got.tx_byte, got.reading, got.error_code);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
         compare_field("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
         compare_field("reading", want.reading, got.reading);
         compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = fsl_pkg::CSR_LINK_ENABLE;
   logic [39:0] csr_wdata = '0;

   // Percent chance per cycle that the sender idles / the receiver stalls
   int idle_pct  = 0;
   int stall_pct = 0;
   // While set, a byte that would advance the handshake is spoiled into a bad end
   bit guard_phase = 1'b1;
   int cycle_count = 0;

   link_scoreboard link_sb = new();

   fsl_req_if req_bus ();
   fsl_rsp_if rsp_bus ();

   framed_sensor_link_handshake u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver side: drop ready at random while a stall phase is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Check every result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         link_sb.check_result({rsp_bus.result_kind, rsp_bus.tx_byte, rsp_bus.reading,
                               rsp_bus.error_code, rsp_bus.last});
      end
   end

   // Offer one byte, hold it until the block takes it, then record it.
   // Valid stays high on return so back-to-back bytes need no extra edge.
   task automatic send_byte(input logic [7:0] b);
      logic [7:0] data;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      data = b;
      if (guard_phase && link_sb.moves_phase(data)) data = data ^ 8'h01;
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      link_sb.note_byte(data);
   endtask

   task automatic send_framed(input logic [7:0] d0, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [7:0] close_byte);
      send_byte(link_sb.cfg.start_byte);
      send_byte(d0);
      send_byte(d1);
      send_byte(d2);
      send_byte(close_byte);
   endtask

   // Drop valid, wait for every owed result, then let the pipeline go quiet
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (link_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; finish a batch with end_writes
   task automatic write_reg(input logic [2:0] idx, input logic [39:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      link_sb.set_reg(idx, value);
   endtask

   task automatic end_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Random upper bits on top of a register value: the block must mask them off
   function automatic logic [39:0] noisy(input logic [39:0] value, input int width);
      logic [39:0] junk;
      junk = {8'($urandom), 32'($urandom)};
      return (junk << width) | value;
   endfunction

   // Mostly well-formed frames with random content, plus stray bytes and bad ends.
   // In the id phase the tag and the id are often planted to reach those checks.
   task automatic random_traffic(input int count);
      int         sent;
      int         pick;
      logic [7:0] fill [3];
      logic [7:0] close_byte;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            foreach (fill[k]) fill[k] = 8'($urandom_range(0, 255));
            if (link_sb.phase == fsl_pkg::PH_ID) begin
               if ($urandom_range(0, 1)) fill[0] = {3'b000, link_sb.cfg.sensor_id};
               if ($urandom_range(0, 1)) fill[1] = fsl_pkg::CHAR_I;
               if ($urandom_range(0, 1)) fill[2] = fsl_pkg::CHAR_D;
            end
            close_byte = (pick < 25) ? 8'($urandom_range(0, 255)) : link_sb.cfg.end_byte;
            send_framed(fill[0], fill[1], fill[2], close_byte);
            sent += 5;
         end
      end
   endtask

   task automatic set_pressure(input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   initial begin
      logic [39:0] hello;
      bit          take_fatal;

      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: stray bytes, a bad end marker, a frame that is not hello
      send_byte(8'hFF);
      send_byte(8'h00);
      send_framed(8'h01, 8'h02, 8'h03, 8'h00);
      send_framed(8'h00, 8'h00, 8'h00, link_sb.cfg.end_byte);
      drain();

      // Disabled link: bytes vanish without a result
      write_reg(fsl_pkg::CSR_LINK_ENABLE, noisy(40'd0, 1));
      end_writes();
      send_byte(fsl_pkg::RST_START_BYTE);
      send_byte(8'hA5);
      drain();

      // Extreme markers, all-ones ack, all-zero ready, top sensor id
      hello = {8'h00, 24'($urandom), 8'hFF};
      write_reg(fsl_pkg::CSR_LINK_ENABLE, noisy(40'd1, 1));
      write_reg(fsl_pkg::CSR_START_BYTE, noisy(40'h00, 8));
      write_reg(fsl_pkg::CSR_END_BYTE, noisy(40'hFF, 8));
      write_reg(fsl_pkg::CSR_HELLO_FRAME, hello);
      write_reg(fsl_pkg::CSR_ACK_FRAME, '1);
      write_reg(fsl_pkg::CSR_READY_FRAME, '0);
      write_reg(fsl_pkg::CSR_SENSOR_ID, noisy(40'd31, 5));
      write_reg(CSR_UNUSED, {8'($urandom), 32'($urandom)});
      end_writes();

      // Hello phase under random traffic, back-to-back
      set_pressure(0, 0);
      random_traffic(40);

      // Correct hello: expect the ack frame, then an id frame missing its tag
      guard_phase = 1'b0;
      send_framed(hello[31:24], hello[23:16], hello[15:8], link_sb.cfg.end_byte);
      guard_phase = 1'b1;
      send_framed(8'd31, fsl_pkg::CHAR_I, 8'h00, link_sb.cfg.end_byte);

      // Id phase under random traffic with a slow sender
      set_pressure(66, 0);
      random_traffic(30);
      drain();

      // Halting is permanent without a reset, so the seed picks which way the
      // handshake ends: a wrong id on some runs, the full data phase on the rest
      take_fatal = ($urandom_range(0, 3) == 0);
      set_pressure(0, 0);
      guard_phase = 1'b0;
      if (take_fatal) begin
         send_framed(8'd31 ^ 8'h01, fsl_pkg::CHAR_I, fsl_pkg::CHAR_D, link_sb.cfg.end_byte);
         drain();
         // Halted: bytes are ignored and a register write does not revive the link
         send_framed(8'h00, 8'hFF, 8'hFF, link_sb.cfg.end_byte);
         drain();
         write_reg(fsl_pkg::CSR_LINK_ENABLE, noisy(40'd1, 1));
         end_writes();
         send_byte(link_sb.cfg.start_byte);
         send_byte(8'h7E);
         drain();

         // Keep the halted link busy under each idling pattern
         set_pressure(0, 66);
         random_traffic(70);
         set_pressure(66, 0);
         random_traffic(70);
         set_pressure(11, 11);
         random_traffic(70);
         drain();
      end else begin
         send_framed(8'd31, fsl_pkg::CHAR_I, fsl_pkg::CHAR_D, link_sb.cfg.end_byte);
         guard_phase = 1'b1;
         send_framed(8'h5A, 8'hFF, 8'hFF, link_sb.cfg.end_byte);
         send_framed(8'hA5, 8'h00, 8'h00, link_sb.cfg.end_byte);
         drain();

         // Data phase, swapped extreme markers, slow receiver
         write_reg(fsl_pkg::CSR_START_BYTE, noisy(40'hFF, 8));
         write_reg(fsl_pkg::CSR_END_BYTE, noisy(40'h00, 8));
         write_reg(fsl_pkg::CSR_HELLO_FRAME, '1);
         write_reg(fsl_pkg::CSR_SENSOR_ID, noisy(40'd0, 5));
         end_writes();
         set_pressure(0, 66);
         random_traffic(50);
         drain();

         // Random markers, slow sender; pause once until everything owed is out
         write_reg(fsl_pkg::CSR_START_BYTE, 40'($urandom_range(0, 255)));
         write_reg(fsl_pkg::CSR_END_BYTE, 40'($urandom_range(0, 255)));
         write_reg(fsl_pkg::CSR_ACK_FRAME, {8'($urandom), 32'($urandom)});
         write_reg(fsl_pkg::CSR_READY_FRAME, {8'($urandom), 32'($urandom)});
         end_writes();
         set_pressure(66, 0);
         random_traffic(25);
         drain();
         random_traffic(25);
         drain();

         // Light idling on both sides, disabled for a stretch first
         write_reg(fsl_pkg::CSR_LINK_ENABLE, 40'd0);
         end_writes();
         set_pressure(11, 11);
         random_traffic(10);
         drain();
         write_reg(fsl_pkg::CSR_LINK_ENABLE, 40'd1);
         write_reg(fsl_pkg::CSR_START_BYTE, 40'(fsl_pkg::RST_START_BYTE));
         write_reg(fsl_pkg::CSR_END_BYTE, 40'(fsl_pkg::RST_END_BYTE));
         end_writes();
         random_traffic(50);
         drain();

         // No idling at all to finish
         set_pressure(0, 0);
         random_traffic(50);
         drain();
      end

      if (link_sb.failures == 0 && link_sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/fsl_pkg.sv
hdl/fsl_req_if.sv
hdl/fsl_rsp_if.sv
hdl/fsl_front.sv
hdl/fsl_queue.sv
hdl/fsl_back.sv
hdl/framed_sensor_link_handshake.sv
bench/tb_top.sv
